>>> rtl/lrt_pkg.sv
// lrt_pkg: shared types and constants of the recency tracker
// command codes, field widths and the layout of one stored entry
// no dependencies
package lrt_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 32;
	localparam int CMD_W = 3;
	localparam int WANT_W = 7;
	localparam int CAP_W = 7;

	// longest candidate list for one query
	localparam int LIST_MAX = 64;

	// reset value of the capacity register
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ACCESS = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LIST   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STATS  = 3'd4;

	// one table entry, stored in recency order
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} entry_t;

	// one result item
	typedef struct packed {
		logic [KEY_W-1:0] entry_key;
		logic             found;
		logic             inserted;
		logic             last_item;
		logic [31:0]      count_sum;
		logic [31:0]      access_total;
	} result_t;

endpackage

>>> rtl/lru_recency_tracker.sv
// lru_recency_tracker: keys with use counts held in recency order in one memory
// entry memory (key, count), walked one position per cycle; depends on lrt_pkg
// Access, remove and statistics walk the occupied entries, then emit the result;
//   an access hit on a full table walks twice, shifting entries on the second walk.
// Eviction list: least recent first, one item per cycle while the result channel does not stall.
// Requests: a new request is taken only in the idle state, so one request at a time.
// Reset: capacity returns to 64, occupancy and the access clock clear at once;
//   the entry memory is not cleared, entries past the occupancy are never used.
module lru_recency_tracker #(
	parameter int ENTRIES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [lrt_pkg::CMD_W-1:0]   command,
	input  logic [lrt_pkg::KEY_W-1:0]   key,
	input  logic [lrt_pkg::WANT_W-1:0]  want_count,
	// result channel
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [lrt_pkg::KEY_W-1:0]   entry_key,
	output logic                        found,
	output logic                        inserted,
	output logic                        last_item,
	output logic [31:0]                 count_sum,
	output logic [31:0]                 access_total,
	// capacity register write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lrt_pkg::CAP_W-1:0]   cfg_data
);
	import lrt_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LIST = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     ptr_q;
	logic [CW-1:0]     occ_q;
	logic [6:0]        left_q;
	logic [CMD_W-1:0]  cmd_q;
	logic              shift_q;
	logic              found_q;
	logic [31:0]       clock_q;
	logic [CAP_W-1:0]  cap_q;
	logic [KEY_W-1:0]  key_q;
	logic [31:0]       sum_q;
	logic              out_valid_q;
	result_t           out_q;

	entry_t            entry_mem_q [ENTRIES];
	entry_t            rdata_q;

	logic              accept;
	logic              out_free;
	logic              out_ld;
	result_t           out_d;
	logic [LW-1:0]     cap_lim;
	logic              room;
	logic [LW-1:0]     occ_lim;
	logic [LW-1:0]     list_n;
	logic [CW-1:0]     ptr_next;
	logic [CW-1:0]     ptr_prev;
	logic [CW-1:0]     occ_last;
	logic              in_range;
	logic              match;
	logic [CNT_W-1:0]  cnt_inc;
	logic [32:0]       sum_add;
	logic [31:0]       sum_next;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;
	logic [AW-1:0]     rd_addr;

	// handshakes
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid & ~req_stall;
	assign out_free  = ~out_valid_q | ~rsp_stall;
	assign cfg_ready = 1'b1;

	// limits from capacity and list length
	assign cap_lim  = (LW'(cap_q) > LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(cap_q);
	assign room     = LW'(occ_q) < cap_lim;
	assign occ_lim  = (LW'(occ_q) > LW'(LIST_MAX)) ? LW'(LIST_MAX) : LW'(occ_q);
	assign list_n   = (LW'(want_count) < occ_lim) ? LW'(want_count) : occ_lim;

	// walk pointer arithmetic
	assign ptr_next = ptr_q + 1'b1;
	assign ptr_prev = ptr_q - 1'b1;
	assign occ_last = occ_q - 1'b1;
	assign in_range = ptr_q < occ_q;

	// entry under the walk pointer
	assign match    = (rdata_q.key == key_q);
	assign cnt_inc  = (&rdata_q.count) ? rdata_q.count : rdata_q.count + 1'b1;
	assign sum_add  = {1'b0, sum_q} + {1'b0, rdata_q.count};
	assign sum_next = sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];

	// memory read address and write-back
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		rd_addr   = ptr_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_LIST) begin
					rd_addr = occ_last[AW-1:0];
				end else begin
					rd_addr = '0;
				end
			end
			ST_SCAN: begin
				rd_addr = ptr_next[AW-1:0];
				if (in_range) begin
					case (cmd_q)
						CMD_ACCESS: begin
							if (match) begin
								// hit: with room shifted so far, place it first; else rewalk
								rd_addr = '0;
								if (shift_q) begin
									mem_we    = 1'b1;
									mem_waddr = '0;
									mem_wdata = '{key: key_q, count: cnt_inc};
								end
							end else if (shift_q) begin
								mem_we    = 1'b1;
								mem_waddr = ptr_next[AW-1:0];
								mem_wdata = rdata_q;
							end
						end
						CMD_REMOVE: begin
							// after the hit, close the gap one entry at a time
							if (found_q) begin
								mem_we    = 1'b1;
								mem_waddr = ptr_prev[AW-1:0];
								mem_wdata = rdata_q;
							end
						end
						default: begin
						end
					endcase
				end else if (cmd_q == CMD_ACCESS && shift_q) begin
					// miss with room: new key becomes most recent
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = '{key: key_q, count: CNT_W'(1)};
				end
			end
			ST_LIST: begin
				if (out_free && left_q != 7'd1) begin
					rd_addr = ptr_prev[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// entry memory, read first on a same-address write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= entry_mem_q[rd_addr];
	end

	// result item selection
	always_comb begin
		out_ld = 1'b0;
		out_d  = '{entry_key: key_q, found: 1'b0, inserted: 1'b0, last_item: 1'b1,
			count_sum: 32'd0, access_total: 32'd0};
		case (state_q)
			ST_EMIT: begin
				out_ld = out_free;
				case (cmd_q)
					CMD_ACCESS: begin
						out_d.found    = found_q;
						out_d.inserted = ~found_q & shift_q;
					end
					CMD_REMOVE: begin
						out_d.found = found_q;
					end
					CMD_STATS: begin
						out_d.count_sum    = sum_q;
						out_d.access_total = clock_q;
					end
					default: begin
					end
				endcase
			end
			ST_LIST: begin
				out_ld          = out_free;
				out_d.entry_key = rdata_q.key;
				out_d.found     = 1'b1;
				out_d.last_item = (left_q == 7'd1);
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			occ_q       <= '0;
			left_q      <= '0;
			cmd_q       <= CMD_ACCESS;
			shift_q     <= 1'b0;
			found_q     <= 1'b0;
			clock_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end

			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						ptr_q   <= '0;
						found_q <= 1'b0;
						shift_q <= room;
						case (command)
							CMD_ACCESS: begin
								if (!(&clock_q)) begin
									clock_q <= clock_q + 1'b1;
								end
								state_q <= ST_SCAN;
							end
							CMD_REMOVE, CMD_STATS: begin
								state_q <= ST_SCAN;
							end
							CMD_CLEAR: begin
								occ_q   <= '0;
								state_q <= ST_EMIT;
							end
							CMD_LIST: begin
								if (list_n == '0) begin
									state_q <= ST_EMIT;
								end else begin
									left_q  <= 7'(list_n);
									ptr_q   <= occ_last;
									state_q <= ST_LIST;
								end
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (in_range) begin
						ptr_q <= ptr_next;
						if (cmd_q == CMD_ACCESS && match) begin
							if (shift_q) begin
								found_q <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								// full table: walk again, shifting up to the hit
								shift_q <= 1'b1;
								ptr_q   <= '0;
							end
						end else if (cmd_q == CMD_REMOVE && !found_q && match) begin
							found_q <= 1'b1;
						end
					end else begin
						state_q <= ST_EMIT;
						if (cmd_q == CMD_ACCESS && shift_q) begin
							occ_q <= occ_q + 1'b1;
						end else if (cmd_q == CMD_REMOVE && found_q) begin
							occ_q <= occ_last;
						end
					end
				end
				ST_LIST: begin
					if (out_free) begin
						if (left_q == 7'd1) begin
							state_q <= ST_IDLE;
						end else begin
							ptr_q  <= ptr_prev;
							left_q <= left_q - 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload, statistics sum and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key;
			sum_q <= '0;
		end else if (state_q == ST_SCAN && in_range && cmd_q == CMD_STATS) begin
			sum_q <= sum_next;
		end
		if (out_ld) begin
			out_q <= out_d;
		end
	end

	// result ports
	assign rsp_valid    = out_valid_q;
	assign entry_key    = out_q.entry_key;
	assign found        = out_q.found;
	assign inserted     = out_q.inserted;
	assign last_item    = out_q.last_item;
	assign count_sum    = out_q.count_sum;
	assign access_total = out_q.access_total;

`ifndef SYNTHESIS
	// occupancy stays within the table
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(ENTRIES))
		else $error("occupancy beyond table depth");

	// occupancy grows only by one, and only through an access
	a_occ_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q > $past(occ_q)) |->
		($past(cmd_q) == CMD_ACCESS && occ_q == $past(occ_q) + 1'b1))
		else $error("occupancy grew outside an access insert");

	// memory is written only during a walk
	a_we_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SCAN))
		else $error("entry memory written outside a walk");

	// a candidate list never runs out of items before its last one
	a_list_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIST) |-> (left_q != 7'd0 && ptr_q < occ_q))
		else $error("candidate list pointer out of range");
`endif

endmodule
